>>> rtl/sha256_stream_hasher_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/shs_pkg.sv
package shs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockW = 512;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBytesAt = 56;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic start;
    logic init;
  } shs_ctrl_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> rtl/shs_core.sv
module shs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  shs_pkg::shs_ctrl_t            ctrl_i,
  input  logic [shs_pkg::BlockW-1:0]    block_i,
  output logic                          done_o,
  output shs_pkg::word_t                chain_o [8]
);

  typedef enum logic [1:0] {
    CoreIdle,
    CoreRound,
    CoreFinal
  } core_state_e;

  core_state_e    state_q, state_d;
  logic [5:0]     round_q, round_d;
  shs_pkg::word_t chain_q [8];
  shs_pkg::word_t chain_d [8];
  shs_pkg::word_t v_q [8];
  shs_pkg::word_t v_d [8];
  shs_pkg::word_t w_q [16];
  shs_pkg::word_t w_d [16];

  shs_pkg::word_t t1, t2, ch, maj, w_new;

  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + shs_pkg::big_sigma1(v_q[4]) + ch + shs_pkg::RoundK[round_q] + w_q[0];
    t2    = shs_pkg::big_sigma0(v_q[0]) + maj;
    w_new = shs_pkg::small_sigma1(w_q[14]) + w_q[9] + shs_pkg::small_sigma0(w_q[1]) + w_q[0];
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    chain_d = chain_q;
    v_d     = v_q;
    w_d     = w_q;
    done_o  = 1'b0;
    unique case (state_q)
      CoreIdle: begin
        if (ctrl_i.init) begin
          chain_d = shs_pkg::InitHash;
        end
        if (ctrl_i.start) begin
          v_d     = chain_q;
          round_d = '0;
          for (int i = 0; i < 16; i++) begin
            w_d[i] = block_i[shs_pkg::BlockW-1-32*i -: 32];
          end
          state_d = CoreRound;
        end
      end
      CoreRound: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = w_new;
        round_d = round_q + 6'd1;
        if (round_q == 6'(shs_pkg::Rounds - 1)) begin
          state_d = CoreFinal;
        end
      end
      CoreFinal: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        done_o  = 1'b1;
        state_d = CoreIdle;
      end
      default: state_d = CoreIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoreIdle;
      round_q <= '0;
      chain_q <= shs_pkg::InitHash;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  assign chain_o = chain_q;

endmodule

>>> rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream. Each input item carries at most one message byte and may
// mark the end of the message; the hash state returns to the initial value after every
// digest. A byte item is taken without stalling, except that the 64th byte of a block starts
// a compression in the shared round unit, which runs one round per cycle and holds input
// off until it is done. An end item pads one byte per cycle (pausing while a compression
// runs) up to the length field, runs one or two compressions, and then offers the eight
// digest words, word 0 first, one per cycle while the output is not stalled; no input
// is taken until the last word has been delivered.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLen,
    StComp,
    StEmit
  } state_e;

  state_e      state_q, state_d;
  state_e      after_q, after_d;
  logic        first_q, first_d;
  logic        start_q, start_d;
  logic        out_valid_q, out_valid_d;
  logic [6:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  idx_q, idx_d;
  logic [shs_pkg::BlockW-1:0] buf_q;

  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        core_done;
  shs_pkg::shs_ctrl_t ctrl;
  shs_pkg::word_t     chain [8];

  always_comb begin
    state_d     = state_q;
    after_d     = after_q;
    first_d     = first_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    fill_d      = fill_q;
    len_d       = len_q;
    idx_d       = idx_q;
    shift_en    = 1'b0;
    shift_byte  = data_byte_i;
    ctrl.init   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            shift_en = 1'b1;
            fill_d   = fill_q + 7'd1;
            len_d    = len_q + 64'd8;
          end
          if (has_byte_i && fill_q == 7'(shs_pkg::BlockBytes - 1)) begin
            fill_d  = '0;
            start_d = 1'b1;
            state_d = StComp;
            after_d = end_of_message_i ? StPad : StIdle;
            first_d = 1'b1;
          end else if (end_of_message_i) begin
            state_d = StPad;
            first_d = 1'b1;
          end
        end
      end
      StPad: begin
        shift_byte = first_q ? 8'h80 : 8'h00;
        if (!first_q && fill_q == 7'(shs_pkg::LenBytesAt)) begin
          state_d = StLen;
        end else begin
          shift_en = 1'b1;
          first_d  = 1'b0;
          fill_d   = fill_q + 7'd1;
          if (fill_q == 7'(shs_pkg::BlockBytes - 1)) begin
            fill_d  = '0;
            start_d = 1'b1;
            state_d = StComp;
            after_d = StPad;
          end
        end
      end
      StLen: begin
        shift_byte = len_q[63:56];
        shift_en   = 1'b1;
        len_d      = {len_q[55:0], 8'h00};
        fill_d     = fill_q + 7'd1;
        if (fill_q == 7'(shs_pkg::BlockBytes - 1)) begin
          fill_d  = '0;
          start_d = 1'b1;
          state_d = StComp;
          after_d = StEmit;
        end
      end
      StComp: begin
        if (core_done) begin
          state_d = after_q;
          if (after_q == StEmit) begin
            out_valid_d = 1'b1;
            idx_d       = '0;
          end
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (idx_q == 3'd7) begin
            out_valid_d = 1'b0;
            ctrl.init   = 1'b1;
            len_d       = '0;
            fill_d      = '0;
            state_d     = StIdle;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    ctrl.start = start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      after_q     <= StIdle;
      first_q     <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      after_q     <= after_d;
      first_q     <= first_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      buf_q <= {buf_q[shs_pkg::BlockW-9:0], shift_byte};
    end
  end

  shs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .block_i (buf_q),
    .done_o  (core_done),
    .chain_o (chain)
  );

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = chain[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

>>> rtl/shs_checker.sv
`include "sha256_stream_hasher_macros.svh"

module shs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        has_byte_i,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // No new item may enter while digest words are being delivered.
  `SHS_ASSERT_IMPLY(a_no_input_during_output, clk_i, rst_ni, out_valid_o, in_stall_o)

  `SHS_ASSERT_IMPLY(a_last_flag, clk_i, rst_ni, out_valid_o, last_word_o == (word_index_o == 3'd7))

  `SHS_ASSERT_NEXT(a_hold_when_stalled, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(digest_word_o) && $stable(word_index_o))

  `SHS_ASSERT_NEXT(a_done_after_last, clk_i, rst_ni, out_valid_o && !out_stall_i && last_word_o, !out_valid_o && !in_stall_o)

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

>>> test/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned TailCycles = 200;

  localparam logic [31:0] ChainInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  byte_item_t    feed_q [$];
  digest_entry_t pending_digest [$];

  logic [31:0] hash_h [8] = ChainInit;
  logic [7:0]  blk_bytes [64] = '{default: 8'h00};
  int unsigned blk_count = 0;
  logic [60:0] msg_len = '0;

  int unsigned items_queued = 0;
  int unsigned items_done = 0;
  int unsigned real_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        in_taken = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_started = 1'b0;
  int unsigned hold_left = 0;

  sha256_stream_hasher dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (end_of_message),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_compression();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      hash_h[i] = hash_h[i] + v[i];
    end
  endtask

  task automatic hash_item(logic [7:0] b, logic has, logic eom);
    logic [63:0] bit_len;
    if (has) begin
      blk_bytes[blk_count] = b;
      blk_count++;
      msg_len = msg_len + 61'd1;
      if (blk_count == 64) begin
        run_compression();
        blk_count = 0;
      end
    end
    if (eom) begin
      blk_bytes[blk_count] = 8'h80;
      for (int i = blk_count + 1; i < 64; i++) begin
        blk_bytes[i] = 8'h00;
      end
      if (blk_count >= 56) begin
        run_compression();
        blk_bytes = '{default: 8'h00};
      end
      bit_len = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) begin
        blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
      end
      run_compression();
      for (int i = 0; i < 8; i++) begin
        pending_digest.push_back('{hash_h[i], 3'(i), i == 7});
      end
      hash_h = ChainInit;
      blk_count = 0;
      msg_len = '0;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic offer(logic [7:0] b, logic has, logic eom);
    feed_q.push_back('{b, has, eom});
    items_queued++;
    if (has || eom) begin
      real_items++;
    end
  endtask

  task automatic queue_message(int unsigned len);
    bit split_end;
    split_end = (len == 0) || ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        offer(8'($urandom), 1'b0, 1'b0);
      end
      offer(8'($urandom), 1'b1, !split_end && (i == len - 1));
    end
    if (split_end) begin
      offer(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Lengths cluster around the points where padding spills into an extra block.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 62) begin
      return $urandom_range(12);
    end
    if (r < 94) begin
      case ($urandom_range(5))
        0: return 55;
        1: return 56;
        2: return 63;
        3: return 64;
        4: return 65;
        default: return 120;
      endcase
    end
    return $urandom_range(130, 66);
  endfunction

  task automatic wait_drained();
    while (items_done != items_queued || pending_digest.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin : drive_proc
    byte_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = feed_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.data;
        has_byte <= nxt.has;
        end_of_message <= nxt.eom;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : watch_proc
    digest_entry_t want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        hash_item(data_byte, has_byte, end_of_message);
        items_done++;
      end
      if (out_valid && !out_stall) begin
        if (pending_digest.size() == 0) begin
          report_mismatch($sformatf("digest word %h with nothing pending", digest_word));
        end else begin
          want = pending_digest.pop_front();
          if (digest_word !== want.word) begin
            report_mismatch($sformatf("digest_word %h, expected %h", digest_word, want.word));
          end
          if (word_index !== want.index) begin
            report_mismatch($sformatf("word_index %0d, expected %0d", word_index, want.index));
          end
          if (last_word !== want.last) begin
            report_mismatch($sformatf("last_word %b, expected %b", last_word, want.last));
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("timeout: no item moved for %0d cycles", QuietLimit);
    $display("sha256_stream_hasher_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty message, ignored item, lone byte with end, extreme bytes, short text.
    offer(8'($urandom), 1'b0, 1'b1);
    offer(8'($urandom), 1'b0, 1'b0);
    offer(8'hff, 1'b1, 1'b1);
    offer(8'h00, 1'b1, 1'b0);
    offer(8'($urandom), 1'b0, 1'b1);
    offer(8'h61, 1'b1, 1'b0);
    offer(8'h62, 1'b1, 1'b0);
    offer(8'h63, 1'b1, 1'b1);
    offer(8'h00, 1'b0, 1'b0);
    offer(8'hff, 1'b0, 1'b1);
    offer(8'hff, 1'b1, 1'b0);
    offer(8'h00, 1'b1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_go = 1'b1;
        end
        1: begin
          idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      real_items = 0;
      while (real_items < PhaseItems) begin
        queue_message(pick_length());
      end
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sha256_stream_hasher_tb: PASS");
    end else begin
      $display("sha256_stream_hasher_tb: FAIL");
    end
    $finish;
  end

endmodule
